### src/md5_pkg.sv
// md5_pkg: shared types, constants and helper functions for the md5 digest block
// no dependencies; imported by the controller, the datapath and the top level

package md5_pkg;

   localparam logic [31:0] INIT_A    = 32'h67452301;
   localparam logic [31:0] INIT_B    = 32'hefcdab89;
   localparam logic [31:0] INIT_C    = 32'h98badcfe;
   localparam logic [31:0] INIT_D    = 32'h10325476;
   localparam logic [7:0]  MARK_BYTE = 8'h80;
   localparam logic [2:0]  FULL_BYTES = 3'd4;
   localparam logic [3:0]  LEN_SLOT  = 4'd14;
   localparam logic [3:0]  LAST_SLOT = 4'd15;
   localparam logic [5:0]  LAST_ROUND = 6'd63;
   localparam logic [63:0] WORD_BITS = 64'd32;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_DONE
   } md5_state_type;

   typedef enum logic [2:0] {
      WSEL_INPUT,
      WSEL_MARK,
      WSEL_ZERO,
      WSEL_LEN_LO,
      WSEL_LEN_HI
   } md5_wsel_type;

   typedef struct packed {
      logic         push;
      md5_wsel_type wsel;
      logic         load;
      logic         round;
      logic         fold;
      logic         finish;
   } md5_cmd_type;

   typedef struct packed {
      logic wrap;
      logic at_len;
      logic round_last;
      logic rsp_busy;
   } md5_sts_type;

   function automatic logic [2:0] clamp_count(input logic [2:0] n);
      return (n > FULL_BYTES) ? FULL_BYTES : n;
   endfunction

   // last word: keep the valid low bytes, put the marker right above them
   function automatic logic [31:0] last_word(input logic [31:0] w, input logic [2:0] n);
      logic [31:0] r;
      case (clamp_count(n))
         3'd0: r = {24'h0, MARK_BYTE};
         3'd1: r = {16'h0, MARK_BYTE, w[7:0]};
         3'd2: r = {8'h0, MARK_BYTE, w[15:0]};
         3'd3: r = {MARK_BYTE, w[23:0]};
         default: r = w;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] msg_index(input logic [5:0] r);
      logic [3:0] low;
      logic [3:0] idx;
      low = r[3:0];
      case (r[5:4])
         2'd0: idx = low;
         2'd1: idx = (low << 2) + low + 4'd1;
         2'd2: idx = (low << 1) + low + 4'd5;
         default: idx = (low << 3) - low;
      endcase
      return idx;
   endfunction

   function automatic logic [4:0] rot_of(input logic [5:0] r);
      return ROT_AMOUNT[{r[5:4], r[1:0]}];
   endfunction

   function automatic logic [31:0] mix_f(input logic [1:0] grp, input logic [31:0] b,
                                         input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      case (grp)
         2'd0: f = (b & c) | (~b & d);
         2'd1: f = (d & b) | (~d & c);
         2'd2: f = b ^ c ^ d;
         default: f = c ^ (b | ~d);
      endcase
      return f;
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      logic [63:0] dbl;
      dbl = {v, v} << s;
      return dbl[63:32];
   endfunction

   function automatic logic [31:0] bswap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

### src/md5_if.sv
// md5_if: valid/ready channel interfaces for message words and digests
// no dependencies; used by the md5_digest top level

interface md5_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] msg_word;
   logic [2:0]  byte_count;
   logic        final_word;

   modport source (output valid, msg_word, byte_count, final_word, input ready);
   modport sink (input valid, msg_word, byte_count, final_word, output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_first;
   logic [63:0] digest_second;

   modport source (output valid, digest_first, digest_second, input ready);
   modport sink (input valid, digest_first, digest_second, output ready);
endinterface

### src/md5_ctrl.sv
// md5_ctrl: sequencer for word intake, padding, round iteration and digest release
// depends on md5_pkg; drives the md5_dpath command struct

module md5_ctrl
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  byte_count,
   input  logic        final_word,
   input  md5_sts_type sts,
   output md5_cmd_type cmd
);

   md5_state_type state_ff, state_in;
   logic          mark_ff, mark_in;
   logic          padding_ff, padding_in;
   logic          len_lo_ff, len_lo_in;
   logic          closing_ff, closing_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         mark_ff    <= 1'b0;
         padding_ff <= 1'b0;
         len_lo_ff  <= 1'b0;
         closing_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mark_ff    <= mark_in;
         padding_ff <= padding_in;
         len_lo_ff  <= len_lo_in;
         closing_ff <= closing_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      mark_in    = mark_ff;
      padding_in = padding_ff;
      len_lo_in  = len_lo_ff;
      closing_in = closing_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      cmd.wsel   = WSEL_INPUT;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.push = 1'b1;
               cmd.wsel = WSEL_INPUT;
               if (final_word) begin
                  padding_in = 1'b1;
                  mark_in    = (clamp_count(byte_count) == FULL_BYTES);
               end
               if (sts.wrap) begin
                  state_in = ST_LOAD;
               end else if (final_word) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            cmd.push = 1'b1;
            if (mark_ff) begin
               cmd.wsel = WSEL_MARK;
               mark_in  = 1'b0;
            end else if (len_lo_ff) begin
               cmd.wsel   = WSEL_LEN_HI;
               len_lo_in  = 1'b0;
               closing_in = 1'b1;
            end else if (!sts.at_len) begin
               cmd.wsel = WSEL_ZERO;
            end else begin
               cmd.wsel  = WSEL_LEN_LO;
               len_lo_in = 1'b1;
            end
            if (sts.wrap) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (sts.round_last) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (closing_ff) begin
               state_in = ST_DONE;
            end else if (padding_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.finish = 1'b1;
               padding_in = 1'b0;
               closing_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_round_to_fold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && sts.round_last) |=> (state_ff == ST_FOLD))
      else $error("last round not followed by fold");

   a_wrap_to_load: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && sts.wrap) |=> (state_ff == ST_LOAD))
      else $error("full block did not start compression");

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !sts.rsp_busy)
      else $error("digest overwritten before transfer");

   a_intake_clean: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!padding_ff && !mark_ff && !len_lo_ff && !closing_ff))
      else $error("intake open with padding pending");

endmodule

### src/md5_dpath.sv
// md5_dpath: block buffer, length counter, chaining and working words, round unit
// depends on md5_pkg; controlled by md5_ctrl through command and status structs

module md5_dpath
   import md5_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  md5_cmd_type cmd,
   output md5_sts_type sts,
   input  logic [31:0] msg_word,
   input  logic [2:0]  byte_count,
   input  logic        final_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] digest_first,
   output logic [63:0] digest_second
);

   logic [31:0] blk_ff [16];
   logic [31:0] blk_in;
   logic [3:0]  index_ff, index_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] work_ff [4];
   logic [31:0] work_in [4];
   logic [5:0]  round_ff, round_in;
   logic [5:0]  round_next;
   logic [31:0] mk_ff, mk_in;
   logic [31:0] sum_t;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] first_ff, first_in;
   logic [63:0] second_ff, second_in;

   always_comb begin
      case (cmd.wsel)
         WSEL_INPUT:  blk_in = final_word ? last_word(msg_word, byte_count) : msg_word;
         WSEL_MARK:   blk_in = {24'h0, MARK_BYTE};
         WSEL_LEN_LO: blk_in = bitlen_ff[31:0];
         WSEL_LEN_HI: blk_in = bitlen_ff[63:32];
         default:     blk_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         blk_ff[index_ff] <= blk_in;
      end
   end

   assign round_next = round_ff + 6'd1;
   assign sum_t = work_ff[0] + mix_f(round_ff[5:4], work_ff[1], work_ff[2], work_ff[3]) + mk_ff;

   always_comb begin
      index_in     = index_ff;
      bitlen_in    = bitlen_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      round_in     = round_ff;
      mk_in        = mk_ff;
      rsp_valid_in = rsp_valid_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.push) begin
         index_in = index_ff + 4'd1;
         if (cmd.wsel == WSEL_INPUT) begin
            bitlen_in = bitlen_ff + (final_word ?
                        {58'h0, clamp_count(byte_count), 3'b000} : WORD_BITS);
         end
      end
      if (cmd.load) begin
         work_in  = chain_ff;
         round_in = '0;
         mk_in    = blk_ff[0] + ROUND_CONST[0];
      end
      if (cmd.round) begin
         work_in[0] = work_ff[3];
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[1] + rotl32(sum_t, rot_of(round_ff));
         round_in   = round_next;
         mk_in      = blk_ff[msg_index(round_next)] + ROUND_CONST[round_next];
      end
      if (cmd.fold) begin
         for (int i = 0; i < 4; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
      if (cmd.finish) begin
         first_in     = {bswap32(chain_ff[0]), bswap32(chain_ff[1])};
         second_in    = {bswap32(chain_ff[2]), bswap32(chain_ff[3])};
         rsp_valid_in = 1'b1;
         chain_in     = '{INIT_A, INIT_B, INIT_C, INIT_D};
         work_in      = '{32'h0, 32'h0, 32'h0, 32'h0};
         bitlen_in    = '0;
         index_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= '0;
         bitlen_ff    <= '0;
         chain_ff     <= '{INIT_A, INIT_B, INIT_C, INIT_D};
         work_ff      <= '{32'h0, 32'h0, 32'h0, 32'h0};
         round_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         index_ff     <= index_in;
         bitlen_ff    <= bitlen_in;
         chain_ff     <= chain_in;
         work_ff      <= work_in;
         round_ff     <= round_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mk_ff     <= mk_in;
      first_ff  <= first_in;
      second_ff <= second_in;
   end

   assign sts.wrap       = (index_ff == LAST_SLOT);
   assign sts.at_len     = (index_ff == LEN_SLOT);
   assign sts.round_last = (round_ff == LAST_ROUND);
   assign sts.rsp_busy   = rsp_valid_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign digest_first  = first_ff;
   assign digest_second = second_ff;

endmodule

### src/md5_digest.sv
// md5 digest: in the idle state a non-final word that leaves the block open is accepted; the sixteenth
// word of a block starts a busy compression (load, 64 rounds at one per cycle, fold) run by the
// single round unit, and no new word is taken until it ends. the final word adds the padding
// words and one or two compressions before the digest is registered.
// synchronous reset restores the md5 initial chaining words and clears length and index
// depends on md5_pkg, md5_if, md5_ctrl and md5_dpath

module md5_digest
   import md5_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   md5_req_if.sink   req_bus,
   md5_rsp_if.source rsp_bus
);

   md5_cmd_type cmd;
   md5_sts_type sts;

   md5_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_bus.ready),
      .byte_count (req_bus.byte_count),
      .final_word (req_bus.final_word),
      .sts        (sts),
      .cmd        (cmd)
   );

   md5_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .msg_word      (req_bus.msg_word),
      .byte_count    (req_bus.byte_count),
      .final_word    (req_bus.final_word),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .digest_first  (rsp_bus.digest_first),
      .digest_second (rsp_bus.digest_second)
   );

endmodule

### bench/tb_md5_digest.sv
// tb_md5_digest: self-checking bench for the md5 digest block; streams directed and random
// messages word by word and checks every digest against a scoreboard that hashes the same words
// depends on md5_if and md5_digest

module tb_md5_digest;

   localparam int unsigned HALF_PERIOD  = 4;
   localparam int unsigned RESET_CYCLES = 10;
   localparam int unsigned IDLE_LIMIT   = 5000;
   localparam int unsigned WORD_TARGET  = 1750;
   localparam int unsigned DRAIN_CYCLES = 200;

   class md5_scoreboard;
      logic [31:0]  chain [4];
      logic [31:0]  msg_block [16];
      logic [31:0]  round_k [64];
      logic [4:0]   round_s [16];
      int unsigned  fill;
      logic [63:0]  msg_bits;
      logic [127:0] digest_queue [$];
      int unsigned  errors;

      function new();
         round_k = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
         };
         round_s = '{
            5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
            5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
         };
         errors = 0;
         restart();
      endfunction

      function void restart();
         chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
         foreach (msg_block[i]) msg_block[i] = '0;
         fill = 0;
         msg_bits = '0;
      endfunction

      function logic [31:0] byte_rev(input logic [31:0] v);
         return {v[7:0], v[15:8], v[23:16], v[31:24]};
      endfunction

      function void compress();
         logic [31:0] a, b, c, d, f, t;
         logic [4:0]  s;
         int          g;
         a = chain[0];
         b = chain[1];
         c = chain[2];
         d = chain[3];
         for (int r = 0; r < 64; r++) begin
            case (r / 16)
               0: begin
                  f = (b & c) | (~b & d);
                  g = r;
               end
               1: begin
                  f = (d & b) | (~d & c);
                  g = (5 * r + 1) % 16;
               end
               2: begin
                  f = b ^ c ^ d;
                  g = (3 * r + 5) % 16;
               end
               default: begin
                  f = c ^ (b | ~d);
                  g = (7 * r) % 16;
               end
            endcase
            t = a + f + round_k[r] + msg_block[g];
            s = round_s[(r / 16) * 4 + r % 4];
            a = d;
            d = c;
            c = b;
            b = b + ((t << s) | (t >> (6'd32 - s)));
         end
         chain[0] += a;
         chain[1] += b;
         chain[2] += c;
         chain[3] += d;
      endfunction

      function void absorb(input logic [31:0] w);
         msg_block[fill] = w;
         fill = (fill + 1) % 16;
         if (fill == 0) compress();
      endfunction

      // accepted input transfer: hash the word, queue a digest on the final word
      function void note_word(input logic [31:0] w, input logic [2:0] n, input logic fin);
         logic [31:0] kept;
         int unsigned cnt;
         if (!fin) begin
            msg_bits += 64'd32;
            absorb(w);
            return;
         end
         cnt = (n > 3'd4) ? 4 : n;
         kept = '0;
         for (int i = 0; i < 4; i++) begin
            if (i < cnt) kept[8*i +: 8] = w[8*i +: 8];
         end
         msg_bits += 64'(8 * cnt);
         if (cnt < 4) begin
            kept[8*cnt +: 8] = 8'h80;
            absorb(kept);
         end else begin
            absorb(kept);
            absorb(32'h80);
         end
         while (fill != 14) absorb(32'h0);
         absorb(msg_bits[31:0]);
         absorb(msg_bits[63:32]);
         digest_queue.push_back({byte_rev(chain[0]), byte_rev(chain[1]),
                                 byte_rev(chain[2]), byte_rev(chain[3])});
         restart();
      endfunction

      // accepted result transfer: compare with the oldest queued digest
      function void check_digest(input logic [63:0] first, input logic [63:0] second);
         logic [127:0] want;
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected digest %h %h", $time, first, second);
            errors++;
            return;
         end
         want = digest_queue.pop_front();
         if (first !== want[127:64]) begin
            $display("%0t: digest_first expected %h actual %h", $time, want[127:64], first);
            errors++;
         end
         if (second !== want[63:0]) begin
            $display("%0t: digest_second expected %h actual %h", $time, want[63:0], second);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   md5_req_if req_ch ();
   md5_rsp_if rsp_ch ();

   md5_digest i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   md5_scoreboard sb;
   bit            burst_mode = 1'b0;
   int unsigned   words_sent = 0;
   int unsigned   idle_cycles = 0;
   int unsigned   stall_left = 0;
   int unsigned   calm_left = 0;

   always #HALF_PERIOD clock = ~clock;

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] random_word();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 32'h0;
      if (r == 1) return 32'hffffffff;
      return $urandom;
   endfunction

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r < 5) return $urandom_range(1, 4);
      if (r < 12) return $urandom_range(13, 18);
      if (r < 15) return $urandom_range(29, 34);
      if (r < 18) return $urandom_range(5, 12);
      return $urandom_range(35, 70);
   endfunction

   task automatic send_word(input logic [31:0] w, input logic [2:0] n, input logic fin);
      int unsigned gap;
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid      <= 1'b1;
      req_ch.msg_word   <= w;
      req_ch.byte_count <= n;
      req_ch.final_word <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_word(w, n, fin);
      words_sent++;
   endtask

   task automatic send_message(input int unsigned len, input logic [2:0] last_count);
      for (int unsigned i = 1; i < len; i++) begin
         send_word(random_word(), 3'($urandom_range(0, 7)), 1'b0);
      end
      send_word(random_word(), last_count, 1'b1);
   endtask

   // result side backpressure: short stalls, rare long ones, and calm stretches
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (calm_left != 0) begin
            calm_left--;
         end else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: stall_left = $urandom_range(1, 3);
               4:          stall_left = $urandom_range(20, 60);
               5, 6:       calm_left = $urandom_range(100, 400);
               default:    ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_digest(rsp_ch.digest_first, rsp_ch.digest_second);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      req_ch.valid      = 1'b0;
      req_ch.msg_word   = '0;
      req_ch.byte_count = '0;
      req_ch.final_word = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty message, short tails with junk above the count, oversized counts
      send_word(32'hffffffff, 3'd0, 1'b1);
      send_word(32'hffffffff, 3'd1, 1'b1);
      send_word(32'ha5a5a5a5, 3'd2, 1'b1);
      send_word(32'h00636261, 3'd3, 1'b1);
      send_word(32'hffffffff, 3'd4, 1'b1);
      send_word(32'h12345678, 3'd5, 1'b1);
      send_word(32'h00000000, 3'd7, 1'b1);
      send_word(32'hffffffff, 3'd0, 1'b0);
      send_word(32'h80000001, 3'd6, 1'b1);
      // full final word in slot 13 pushes the length into a second block
      send_message(14, 3'd4);

      while (words_sent < WORD_TARGET) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         send_message(pick_length(), 3'($urandom_range(0, 7)));
      end
      @(negedge clock);
      req_ch.valid <= 1'b0;

      while (sb.digest_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
